@@ design/linear_kalman_filter_step_core_defines.svh @@
// Assertion macros shared by the filter step core.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LINEAR_KALMAN_FILTER_STEP_CORE_DEFINES_SVH
`define LINEAR_KALMAN_FILTER_STEP_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked assertion that is switched off while reset is high.
`define LKF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define LKF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LKF_ASSERT(lbl, clk, rst, prop, msg)
`define LKF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ design/lkf_pkg.sv @@
// Shared types, constants, step program and fixed-point helpers of the filter core.
// No dependencies; imported by the divider and the top-level core.
package lkf_pkg;

  localparam int STATE_DIM = 4;
  localparam int MEAS_DIM  = 2;
  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;

  localparam int DIM_MAX = (STATE_DIM > MEAS_DIM) ? STATE_DIM : MEAS_DIM;
  localparam int IDX_W   = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int CNT_MAX = (DIM_MAX > 2 * MEAS_DIM) ? DIM_MAX : 2 * MEAS_DIM;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);
  localparam int REG_W   = 4;
  localparam int ADDR_W  = REG_W + 2 * IDX_W;
  localparam int DIV_W   = DW + FRAC_BITS;
  localparam int DIV_CW  = $clog2(DIV_W + 1);

  localparam logic [CNT_W-1:0] SD     = CNT_W'(STATE_DIM);
  localparam logic [CNT_W-1:0] MD     = CNT_W'(MEAS_DIM);
  localparam logic [CNT_W-1:0] TWO_MD = CNT_W'(2 * MEAS_DIM);
  localparam logic [CNT_W-1:0] C0     = CNT_W'(0);
  localparam logic [CNT_W-1:0] C1     = CNT_W'(1);

  localparam logic signed [DW-1:0] ONE_Q = DW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [DW-1:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [DW-1:0] Q_MIN = 32'sh80000000;

  // Input item codes.
  localparam logic       OP_COEF = 1'b0;
  localparam logic       OP_MEAS = 1'b1;
  localparam logic [1:0] SEL_A   = 2'd0;
  localparam logic [1:0] SEL_H   = 2'd1;
  localparam logic [1:0] SEL_Q   = 2'd2;
  localparam logic [1:0] SEL_R   = 2'd3;

  // Memory regions, one matrix each.
  typedef enum logic [REG_W-1:0] {
    RG_X, RG_P, RG_A, RG_H, RG_Q, RG_R, RG_Z, RG_XP,
    RG_T1, RG_PP, RG_T2, RG_S, RG_M, RG_INV, RG_K, RG_KH
  } region_t;

  typedef enum logic [1:0] {PO_NONE, PO_ADD, PO_RSUB, PO_RSUB_ID} post_t;
  typedef enum logic [1:0] {OK_MM, OK_GJ, OK_OUT} opk_t;

  typedef struct packed {
    opk_t             kind;
    region_t          ra;
    region_t          rb;
    region_t          rc;
    region_t          ro;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] m;
    logic             tb;
    post_t            post;
  } op_t;

  // Steps of one filter update.
  typedef enum logic [4:0] {
    P_XP, P_T1, P_PP, P_T2, P_S, P_CPM, P_INI, P_GJ, P_T3, P_K,
    P_T4, P_X, P_KH, P_P, P_OUT, P_CPX, P_CPP, P_OUTS
  } pc_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_OP, S_MM_RD, S_MM_MUL, S_MM_ACC, S_PO_RD, S_PO_EX, S_MM_WR,
    S_PV_RD, S_PV_CHK, S_SW_RD, S_SW_WA, S_SW_WB, S_DV_PIV, S_DV_PIVL, S_DV_RD,
    S_DV_ST, S_DV_RUN, S_EL_RDF, S_EL_F, S_EL_RD, S_EL_MUL, S_EL_WR, S_GJ_END,
    S_OUT_RD, S_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic signed [DW-1:0] num;
    logic signed [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] q;
  } div_rsp_t;

  function automatic logic signed [DW-1:0] sat34(input logic signed [DW+1:0] v);
    if (v > 34'(Q_MAX)) return Q_MAX;
    if (v < 34'(Q_MIN)) return Q_MIN;
    return v[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] qadd(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    return sat34(34'(a) + 34'(b));
  endfunction

  function automatic logic signed [DW-1:0] qsub(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    return sat34(34'(a) - 34'(b));
  endfunction

  // Rounds a full product half up to the fraction grid and saturates it.
  function automatic logic signed [DW-1:0] qround(input logic signed [2*DW-1:0] p);
    logic signed [2*DW-1:0] s;
    s = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (s > 64'(Q_MAX)) return Q_MAX;
    if (s < 64'(Q_MIN)) return Q_MIN;
    return s[DW-1:0];
  endfunction

  function automatic op_t mm(input region_t ra, input region_t rb, input region_t rc,
                             input region_t ro, input logic [CNT_W-1:0] n,
                             input logic [CNT_W-1:0] k, input logic [CNT_W-1:0] m,
                             input logic tb, input post_t post);
    op_t o;
    o.kind = OK_MM;
    o.ra = ra;
    o.rb = rb;
    o.rc = rc;
    o.ro = ro;
    o.n = n;
    o.k = k;
    o.m = m;
    o.tb = tb;
    o.post = post;
    return o;
  endfunction

  // The step program: matrix products with an optional final add or subtract, a Gauss-Jordan step and output steps.
  function automatic op_t prog(input pc_t pc);
    op_t o;
    o = mm(RG_X, RG_X, RG_X, RG_X, SD, C0, C1, 1'b0, PO_NONE);
    case (pc)
      P_XP:  o = mm(RG_A, RG_X, RG_X, RG_XP, SD, SD, C1, 1'b0, PO_NONE);
      P_T1:  o = mm(RG_A, RG_P, RG_X, RG_T1, SD, SD, SD, 1'b0, PO_NONE);
      P_PP:  o = mm(RG_T1, RG_A, RG_Q, RG_PP, SD, SD, SD, 1'b1, PO_ADD);
      P_T2:  o = mm(RG_H, RG_PP, RG_X, RG_T2, MD, SD, SD, 1'b0, PO_NONE);
      P_S:   o = mm(RG_T2, RG_H, RG_R, RG_S, MD, SD, MD, 1'b1, PO_ADD);
      P_CPM: o = mm(RG_X, RG_X, RG_S, RG_M, MD, C0, MD, 1'b0, PO_ADD);
      P_INI: o = mm(RG_X, RG_X, RG_X, RG_INV, MD, C0, MD, 1'b0, PO_RSUB_ID);
      P_GJ:  o.kind = OK_GJ;
      P_T3:  o = mm(RG_PP, RG_H, RG_X, RG_T1, SD, SD, MD, 1'b1, PO_NONE);
      P_K:   o = mm(RG_T1, RG_INV, RG_X, RG_K, SD, MD, MD, 1'b0, PO_NONE);
      P_T4:  o = mm(RG_H, RG_XP, RG_Z, RG_T2, MD, SD, C1, 1'b0, PO_RSUB);
      P_X:   o = mm(RG_K, RG_T2, RG_XP, RG_X, SD, MD, C1, 1'b0, PO_ADD);
      P_KH:  o = mm(RG_K, RG_H, RG_X, RG_KH, SD, MD, SD, 1'b0, PO_RSUB_ID);
      P_P:   o = mm(RG_KH, RG_PP, RG_X, RG_P, SD, SD, SD, 1'b0, PO_NONE);
      P_CPX: o = mm(RG_X, RG_X, RG_XP, RG_X, SD, C0, C1, 1'b0, PO_ADD);
      P_CPP: o = mm(RG_X, RG_X, RG_PP, RG_P, SD, C0, SD, 1'b0, PO_ADD);
      P_OUT, P_OUTS: o.kind = OK_OUT;
      default: o.kind = OK_OUT;
    endcase
    return o;
  endfunction

endpackage

@@ design/lkf_ram.sv @@
// Generic synchronous RAM with one write port and two registered read ports.
// No dependencies; holds all matrices of the filter core.
module lkf_ram #(
  parameter int AW = 8,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [2**AW];

  // Write port and both read ports; the reads are registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ design/lkf_div.sv @@
// Bit-serial signed fixed-point divider: (num << FRAC_BITS) / den, saturated.
// Depends on lkf_pkg for widths and the request and response types.
module lkf_div (
  input  logic              clk,
  input  logic              rst,
  input  lkf_pkg::div_req_t req,
  output lkf_pkg::div_rsp_t rsp
);
  import lkf_pkg::*;

  logic [DIV_W-1:0]  quo;
  logic [DW-1:0]     rem;
  logic [DW-1:0]     dmag;
  logic              neg;
  logic              run;
  logic              done;
  logic [DIV_CW-1:0] cnt;
  logic [DW:0]       rsh;
  logic              ge;
  logic [DW-1:0]     amag;
  logic [DW-1:0]     bmag;

  // Magnitudes of the operands and one restoring step.
  always_comb begin
    amag = req.num[DW-1] ? DW'(-req.num) : DW'(req.num);
    bmag = req.den[DW-1] ? DW'(-req.den) : DW'(req.den);
    rsh  = {rem, quo[DIV_W-1]};
    ge   = (rsh >= {1'b0, dmag});
  end

  // One quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= {amag, {FRAC_BITS{1'b0}}};
        rem  <= '0;
        dmag <= bmag;
        neg  <= req.num[DW-1] ^ req.den[DW-1];
        cnt  <= DIV_CW'(DIV_W);
        run  <= 1'b1;
      end else if (run) begin
        rem <= ge ? DW'(rsh - {1'b0, dmag}) : rsh[DW-1:0];
        quo <= {quo[DIV_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Sign and saturation of the finished quotient.
  always_comb begin
    rsp.done = done;
    if (neg) begin
      rsp.q = (quo > DIV_W'(33'h080000000)) ? Q_MIN : DW'(-quo[DW-1:0]);
    end else begin
      rsp.q = (quo > DIV_W'(33'h07fffffff)) ? Q_MAX : quo[DW-1:0];
    end
  end

endmodule

@@ design/linear_kalman_filter_step_core.sv @@
// Kalman filter step core: one matrix memory, a shared multiplier and a divider.
// Coefficient and measurement transactions are taken while idle; the final measurement
// starts a step that runs the step program, with up to 2*MEAS_DIM*MEAS_DIM divisions
// for the inversion, then emits STATE_DIM results as strobes on valid. After reset
// a clearing pass over all 256 memory words loads the zero and identity defaults; busy
// is high during it.
`include "linear_kalman_filter_step_core_defines.svh"
module linear_kalman_filter_step_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [1:0]  which_matrix,
  input  logic [2:0]  row,
  input  logic [2:0]  col,
  input  logic signed [31:0] value,
  input  logic        last,
  output logic        valid,
  output logic [2:0]  element_index,
  output logic signed [31:0] estimate,
  output logic        last_of_run,
  output logic        singular
);
  import lkf_pkg::*;

  state_t state, state_next;
  pc_t    pc;
  op_t    cur;

  logic [ADDR_W-1:0] clr;
  logic [CNT_W-1:0]  i, j, l, c, r, best;
  logic              sing;
  logic [DW-1:0]     bmag;
  logic signed [DW-1:0] acc, tmp, f, piv, rda, rdb, mul_a;
  logic signed [2*DW-1:0] prod;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
  logic [DW-1:0]     wdata, rdata_a, rdata_b;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [DW-1:0]     absv;
  logic              take;
  logic [DW-1:0]     nmag;
  logic [CNT_W-1:0]  nbest;
  logic              mm_last_el;
  region_t           clr_rg;
  region_t           in_rg;
  logic [3:0]        lim_r, lim_c;

  function automatic logic [ADDR_W-1:0] gj_addr(input logic [CNT_W-1:0] rr,
                                                input logic [CNT_W-1:0] jj);
    logic [CNT_W-1:0] jo;
    jo = jj - MD;
    if (jj < MD) return {RG_M, rr[IDX_W-1:0], jj[IDX_W-1:0]};
    return {RG_INV, rr[IDX_W-1:0], jo[IDX_W-1:0]};
  endfunction

  lkf_ram #(.AW(ADDR_W), .DW(DW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(rdata_a), .rdata_b(rdata_b)
  );

  lkf_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // Decode of the current program step and pivot comparison.
  always_comb begin
    cur        = prog(pc);
    rda        = rdata_a;
    rdb        = rdata_b;
    absv       = rda[DW-1] ? DW'(-rda) : DW'(rda);
    take       = (r == c) || (absv > bmag);
    nmag       = take ? absv : bmag;
    nbest      = take ? r : best;
    mm_last_el = (i + C1 == cur.n) && (j + C1 == cur.m);
    mul_a      = (state == S_EL_MUL) ? f : rda;
    clr_rg     = region_t'(clr[ADDR_W-1 -: REG_W]);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr == '1) state_next = S_IDLE;
      S_IDLE:   if (start && op == OP_MEAS && last) state_next = S_OP;
      S_OP: begin
        case (cur.kind)
          OK_MM:   state_next = (cur.k == C0) ? S_PO_RD : S_MM_RD;
          OK_GJ:   state_next = S_PV_RD;
          default: state_next = S_OUT_RD;
        endcase
      end
      S_MM_RD:  state_next = S_MM_MUL;
      S_MM_MUL: state_next = S_MM_ACC;
      S_MM_ACC: state_next = (l + C1 == cur.k) ? S_PO_RD : S_MM_RD;
      S_PO_RD:  state_next = S_PO_EX;
      S_PO_EX:  state_next = S_MM_WR;
      S_MM_WR: begin
        if (mm_last_el) state_next = S_OP;
        else state_next = (cur.k == C0) ? S_PO_RD : S_MM_RD;
      end
      S_PV_RD:  state_next = S_PV_CHK;
      S_PV_CHK: begin
        if (r + C1 == MD) begin
          if (nmag == '0) state_next = S_GJ_END;
          else if (nbest != c) state_next = S_SW_RD;
          else state_next = S_DV_PIV;
        end else begin
          state_next = S_PV_RD;
        end
      end
      S_SW_RD:   state_next = S_SW_WA;
      S_SW_WA:   state_next = S_SW_WB;
      S_SW_WB:   state_next = (j + C1 == TWO_MD) ? S_DV_PIV : S_SW_RD;
      S_DV_PIV:  state_next = S_DV_PIVL;
      S_DV_PIVL: state_next = S_DV_RD;
      S_DV_RD:   state_next = S_DV_ST;
      S_DV_ST:   state_next = S_DV_RUN;
      S_DV_RUN: begin
        if (div_rsp.done) state_next = (j + C1 == TWO_MD) ? S_EL_RDF : S_DV_RD;
      end
      S_EL_RDF: begin
        if (r == MD) state_next = (c + C1 == MD) ? S_GJ_END : S_PV_RD;
        else if (r != c) state_next = S_EL_F;
      end
      S_EL_F:   state_next = S_EL_RD;
      S_EL_RD:  state_next = S_EL_MUL;
      S_EL_MUL: state_next = S_EL_WR;
      S_EL_WR:  state_next = (j + C1 == TWO_MD) ? S_EL_RDF : S_EL_RD;
      S_GJ_END: state_next = S_OP;
      S_OUT_RD: state_next = S_OUT;
      S_OUT:    state_next = (i + C1 == SD) ? S_IDLE : S_OUT_RD;
      default:  state_next = S_IDLE;
    endcase
  end

  // Memory ports, input matrix decode and divider request.
  always_comb begin
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    raddr_a = '0;
    raddr_b = '0;
    div_req = '0;
    in_rg   = RG_A;
    lim_r   = 4'(STATE_DIM);
    lim_c   = 4'(STATE_DIM);
    case (which_matrix)
      SEL_A:   in_rg = RG_A;
      SEL_H:   begin in_rg = RG_H; lim_r = 4'(MEAS_DIM); end
      SEL_Q:   in_rg = RG_Q;
      default: begin in_rg = RG_R; lim_r = 4'(MEAS_DIM); lim_c = 4'(MEAS_DIM); end
    endcase
    case (state)
      S_CLEAR: begin
        we    = (clr_rg != RG_Z);
        waddr = clr;
        wdata = ((clr_rg == RG_Q || clr_rg == RG_R) &&
                 clr[2*IDX_W-1:IDX_W] == clr[IDX_W-1:0]) ? ONE_Q : '0;
      end
      S_IDLE: begin
        wdata = value;
        if (start && op == OP_COEF) begin
          we    = ({1'b0, row} < lim_r) && ({1'b0, col} < lim_c);
          waddr = {in_rg, row[IDX_W-1:0], col[IDX_W-1:0]};
        end else if (start) begin
          we    = ({1'b0, row} < 4'(MEAS_DIM));
          waddr = {RG_Z, row[IDX_W-1:0], {IDX_W{1'b0}}};
        end
      end
      S_MM_RD: begin
        raddr_a = {cur.ra, i[IDX_W-1:0], l[IDX_W-1:0]};
        raddr_b = cur.tb ? {cur.rb, j[IDX_W-1:0], l[IDX_W-1:0]}
                         : {cur.rb, l[IDX_W-1:0], j[IDX_W-1:0]};
      end
      S_PO_RD:  raddr_a = {cur.rc, i[IDX_W-1:0], j[IDX_W-1:0]};
      S_MM_WR: begin
        we    = 1'b1;
        waddr = {cur.ro, i[IDX_W-1:0], j[IDX_W-1:0]};
        wdata = acc;
      end
      S_PV_RD:  raddr_a = gj_addr(r, c);
      S_SW_RD: begin
        raddr_a = gj_addr(c, j);
        raddr_b = gj_addr(best, j);
      end
      S_SW_WA: begin
        we    = 1'b1;
        waddr = gj_addr(c, j);
        wdata = rdb;
      end
      S_SW_WB: begin
        we    = 1'b1;
        waddr = gj_addr(best, j);
        wdata = tmp;
      end
      S_DV_PIV: raddr_a = gj_addr(c, c);
      S_DV_RD:  raddr_a = gj_addr(c, j);
      S_DV_ST: begin
        div_req.start = 1'b1;
        div_req.num   = rda;
        div_req.den   = piv;
      end
      S_DV_RUN: begin
        we    = div_rsp.done;
        waddr = gj_addr(c, j);
        wdata = div_rsp.q;
      end
      S_EL_RDF: raddr_a = gj_addr(r, c);
      S_EL_RD: begin
        raddr_a = gj_addr(r, j);
        raddr_b = gj_addr(c, j);
      end
      S_EL_WR: begin
        we    = 1'b1;
        waddr = gj_addr(r, j);
        wdata = qsub(tmp, qround(prod));
      end
      S_OUT_RD: raddr_a = {RG_X, i[IDX_W-1:0], {IDX_W{1'b0}}};
      default: ;
    endcase
  end

  assign busy          = (state != S_IDLE);
  assign valid         = (state == S_OUT);
  assign estimate      = rda;
  assign element_index = 3'(i);
  assign last_of_run   = (i + C1 == SD);
  assign singular      = sing;

  // Sequencer registers and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
      pc    <= P_XP;
      sing  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: clr <= clr + 1'b1;
        S_IDLE: begin
          if (start && op == OP_MEAS && last) begin
            pc   <= P_XP;
            sing <= 1'b0;
          end
        end
        S_OP: begin
          i   <= C0;
          j   <= C0;
          l   <= C0;
          c   <= C0;
          r   <= C0;
          acc <= '0;
        end
        S_MM_MUL: prod <= mul_a * rdb;
        S_MM_ACC: begin
          acc <= qadd(acc, qround(prod));
          l   <= l + C1;
        end
        S_PO_EX: begin
          case (cur.post)
            PO_ADD:     acc <= qadd(acc, rda);
            PO_RSUB:    acc <= qsub(rda, acc);
            PO_RSUB_ID: acc <= qsub((i == j) ? ONE_Q : '0, acc);
            default:    acc <= acc;
          endcase
        end
        S_MM_WR: begin
          l   <= C0;
          acc <= '0;
          if (j + C1 == cur.m) begin
            j <= C0;
            i <= i + C1;
          end else begin
            j <= j + C1;
          end
          if (mm_last_el) pc <= pc_t'(pc + 1'b1);
        end
        S_PV_CHK: begin
          bmag <= nmag;
          best <= nbest;
          r    <= r + C1;
          j    <= C0;
          if (r + C1 == MD && nmag == '0) sing <= 1'b1;
        end
        S_SW_WA: tmp <= rda;
        S_SW_WB: j <= j + C1;
        S_DV_PIVL: begin
          piv <= rda;
          j   <= C0;
        end
        S_DV_RUN: begin
          if (div_rsp.done) begin
            j <= j + C1;
            r <= C0;
          end
        end
        S_EL_RDF: begin
          if (r == MD) begin
            c <= c + C1;
            r <= c + C1;
          end else if (r == c) begin
            r <= r + C1;
          end
        end
        S_EL_F: begin
          f <= rda;
          j <= C0;
        end
        S_EL_MUL: begin
          prod <= mul_a * rdb;
          tmp  <= rda;
        end
        S_EL_WR: begin
          if (j + C1 == TWO_MD) begin
            j <= C0;
            r <= r + C1;
          end else begin
            j <= j + C1;
          end
        end
        S_GJ_END: pc <= sing ? P_CPX : pc_t'(pc + 1'b1);
        S_OUT:    i <= i + C1;
        default: ;
      endcase
    end
  end

  // Results are single-cycle strobes in a step; checks on step end and divider done.
  `LKF_ASSERT(a_valid_busy, clk, rst, valid |-> busy, "result strobe outside a step")
  `LKF_ASSERT(a_valid_gap, clk, rst, valid |=> !valid, "result strobes not separated")
  `LKF_ASSERT(a_last_idle, clk, rst, valid && last_of_run |=> !busy, "step did not end")
  `LKF_ASSERT(a_div_wait, clk, rst, div_req.start |=> !div_rsp.done, "divider ended early")

endmodule
